/* src/double_ended_queue_assert.svh */
// ----------------------------------------------------------------------------
// double_ended_queue assertion macros
// Shared concurrent assertion forms for the deque checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// next-cycle implication, disabled during reset
`define DEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

/* src/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Types and codes shared by the double-ended queue and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int OCC_W     = 5;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

`default_nettype wire

/* src/double_ended_queue.sv */
// Latency: a result is valid the cycle after its request transaction.
// Throughput: one request per cycle, stalled by a held result; each request
//   does one single-port ring memory access; pop data is its registered read.
// Reset (synchronous, rst_n low): front position, count and result valid
//   clear at once; the ring memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words held in a ring memory with front and count.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_action,
  input  wire logic signed [deq_pkg::WORD_W-1:0] in_push_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_status,
  output logic signed [deq_pkg::WORD_W-1:0]      out_pop_value,
  output logic [deq_pkg::OCC_W-1:0]              out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [deq_pkg::WORD_W-1:0] mem [DEPTH];
  logic signed [deq_pkg::WORD_W-1:0] rd_data_r;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          valid_r, valid_nxt;
  deq_pkg::status_t st;
  deq_pkg::status_t status_r;
  logic          pop_ok_r;
  logic [deq_pkg::OCC_W-1:0] occ_r;

  logic          accept;
  logic          full, empty, pop_ok;
  logic          mem_we, mem_re;
  logic [AW-1:0] addr;
  logic [AW-1:0] front_dec, front_inc, tail_slot, last_slot;
  logic [AW:0]   tail_sum, last_sum;

  // reduce a value below 2*DEPTH into the ring
  function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
    logic [AW:0] d;
    d = (AW+1)'(DEPTH);
    wrap = (v >= d) ? AW'(v - d) : AW'(v);
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = !valid_r || out_ready;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign tail_sum  = {1'b0, front_r} + (AW+1)'(count_r);
  assign last_sum  = tail_sum - 1'b1;  // only used when not empty
  assign tail_slot = wrap(tail_sum);
  assign last_slot = wrap(last_sum);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    addr      = front_r;
    st        = deq_pkg::ST_OK;
    pop_ok    = 1'b0;
    case (deq_pkg::action_t'(in_action))
      deq_pkg::ACT_PUSH_FRONT: begin
        addr = front_dec;
        if (full) begin
          st = deq_pkg::ST_FULL;
        end else begin
          mem_we    = accept;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        addr = tail_slot;
        if (full) begin
          st = deq_pkg::ST_FULL;
        end else begin
          mem_we    = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        addr = front_r;
        if (empty) begin
          st = deq_pkg::ST_EMPTY;
        end else begin
          mem_re    = accept;
          pop_ok    = 1'b1;
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        addr = last_slot;
        if (empty) begin
          st = deq_pkg::ST_EMPTY;
        end else begin
          mem_re    = accept;
          pop_ok    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        st = deq_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      front_nxt = front_r;
      count_nxt = count_r;
    end
  end

  assign valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  // ring memory: one access per request, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= in_push_value;
    end
    if (mem_re) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= st;
      pop_ok_r <= pop_ok;
      occ_r    <= deq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_pop_value = pop_ok_r ? rd_data_r : '0;
  assign out_occupancy = occ_r;

endmodule

`default_nettype wire

/* src/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue, bound into each deque instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_assert.svh"

module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [1:0]                        out_status,
  input wire logic signed [deq_pkg::WORD_W-1:0] out_pop_value,
  input wire logic [deq_pkg::OCC_W-1:0]         out_occupancy
);

  // every request transaction yields a result in the next cycle
  `DEQ_ASSERT_NXT(a_req_to_result, clk, rst_n, in_valid && in_ready, out_valid)

  // a stalled result holds its payload
  `DEQ_ASSERT_NXT(a_result_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_pop_value) && $stable(out_occupancy))

  // refused requests return zero
  `DEQ_ASSERT_IMP(a_refused_zero, clk, rst_n,
    out_valid && (out_status != deq_pkg::ST_OK), out_pop_value == '0)

  // a refused push means the store is at capacity
  `DEQ_ASSERT_IMP(a_full_occ, clk, rst_n,
    out_valid && (out_status == deq_pkg::ST_FULL),
    out_occupancy == deq_pkg::OCC_W'(DEPTH))

  // a refused pop means the store is empty
  `DEQ_ASSERT_IMP(a_empty_occ, clk, rst_n,
    out_valid && (out_status == deq_pkg::ST_EMPTY), out_occupancy == '0)

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_pop_value (out_pop_value),
  .out_occupancy (out_occupancy)
);

`default_nettype wire

/* tb/double_ended_queue_checker.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches the request and result channels of the deque. Each accepted request
// is run through a ring-store model of the deque, and the predicted answer is
// queued. Each accepted result is compared field by field with the oldest
// queued answer. The failure count and the number of answers still due go
// back to the testbench top.
// ----------------------------------------------------------------------------
module double_ended_queue_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        in_action,
  input  logic signed [deq_pkg::WORD_W-1:0] in_push_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [1:0]                        out_status,
  input  logic signed [deq_pkg::WORD_W-1:0] out_pop_value,
  input  logic [deq_pkg::OCC_W-1:0]         out_occupancy,
  output int                                fail_count,
  output int                                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    deq_pkg::status_t                   status;
    logic signed [deq_pkg::WORD_W-1:0]  word;
    logic [deq_pkg::OCC_W-1:0]          occ;
  } deque_answer_t;

  // model of the deque
  logic signed [deq_pkg::WORD_W-1:0] ring [DEPTH];
  int                                head;
  int                                stored;

  deque_answer_t deque_answers[$];
  int            errors = 0;

  function automatic deque_answer_t apply_request(deq_pkg::action_t act,
                                                  logic signed [deq_pkg::WORD_W-1:0] val);
    deque_answer_t ans;
    ans.status = deq_pkg::ST_OK;
    ans.word   = '0;
    case (act)
      deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
        if (stored >= DEPTH) begin
          ans.status = deq_pkg::ST_FULL;
        end else if (act == deq_pkg::ACT_PUSH_FRONT) begin
          head       = (head + DEPTH - 1) % DEPTH;
          ring[head] = val;
          stored++;
        end else begin
          ring[(head + stored) % DEPTH] = val;
          stored++;
        end
      end
      default: begin
        if (stored == 0) begin
          ans.status = deq_pkg::ST_EMPTY;
        end else if (act == deq_pkg::ACT_POP_FRONT) begin
          ans.word = ring[head];
          head     = (head + 1) % DEPTH;
          stored--;
        end else begin
          ans.word = ring[(head + stored - 1) % DEPTH];
          stored--;
        end
      end
    endcase
    ans.occ = stored[deq_pkg::OCC_W-1:0];
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    deque_answer_t want;
    if (!rst_n) begin
      head   = 0;
      stored = 0;
      deque_answers.delete();
    end else begin
      if (in_valid && in_ready)
        deque_answers.push_back(apply_request(deq_pkg::action_t'(in_action),
                                              in_push_value));
      if (out_valid && out_ready) begin
        if (deque_answers.size() == 0) begin
          errors++;
          $display("%0t: result transaction with no request pending: expected none, actual status %0d value %0d occupancy %0d",
                   $time, out_status, out_pop_value, out_occupancy);
        end else begin
          want = deque_answers.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
          if (out_pop_value !== want.word) begin
            errors++;
            $display("%0t: pop value expected %0d, actual %0d",
                     $time, want.word, out_pop_value);
          end
          if (out_occupancy !== want.occ) begin
            errors++;
            $display("%0t: occupancy expected %0d, actual %0d",
                     $time, want.occ, out_occupancy);
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= deque_answers.size();
  end

endmodule

/* tb/tb_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Drives the deque with a directed run (empty pops, extreme words, a fill to
// full with refused pushes) and then with phases of fill-heavy, drain-heavy
// and mixed random requests, with random gaps on both channels. Checking is
// done by double_ended_queue_checker.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1200;
  localparam int DEPTH        = deq_pkg::DEPTH_DEF;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [1:0]                        in_action;
  logic signed [deq_pkg::WORD_W-1:0] in_push_value;
  logic                              out_valid;
  logic                              out_ready;
  logic [1:0]                        out_status;
  logic signed [deq_pkg::WORD_W-1:0] out_pop_value;
  logic [deq_pkg::OCC_W-1:0]         out_occupancy;
  int                                fail_count;
  int                                outstanding;

  // no gaps on either side while set
  bit quiet = 1'b0;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_pop_value (out_pop_value),
    .out_occupancy (out_occupancy)
  );

  double_ended_queue_checker #(.DEPTH(DEPTH)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_pop_value (out_pop_value),
    .out_occupancy (out_occupancy),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= quiet || ($urandom_range(99) >= 13);
    end
  end

  // one request transaction; valid stays up back to back unless a gap is drawn
  task automatic send_request(deq_pkg::action_t act, logic [deq_pkg::WORD_W-1:0] val);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_push_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int                         mode;
    int                         phase_left;
    int                         pop_pct;
    logic                       is_pop;
    logic                       at_back;
    logic [deq_pkg::WORD_W-1:0] word;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = deq_pkg::ACT_PUSH_FRONT;
    in_push_value = '0;
    mode          = 0;
    phase_left    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, extreme words, fill to full, refused pushes
    send_request(deq_pkg::ACT_POP_FRONT, 32'h1234_5678);
    send_request(deq_pkg::ACT_POP_BACK, 32'hFFFF_FFFF);
    send_request(deq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(deq_pkg::ACT_PUSH_BACK, 32'h8000_0000);
    send_request(deq_pkg::ACT_POP_FRONT, '0);
    send_request(deq_pkg::ACT_POP_BACK, '0);
    for (int i = 0; i < DEPTH; i++)
      send_request(i[0] ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT,
                   (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0 : 32'hA5A5_0000 + i);
    send_request(deq_pkg::ACT_PUSH_FRONT, 32'hDEAD_BEEF);
    send_request(deq_pkg::ACT_PUSH_BACK, 32'h0BAD_F00D);
    send_request(deq_pkg::ACT_POP_BACK, '0);

    // random phases steer the queue toward full, toward empty, or hover
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        mode       = $urandom_range(2);
        phase_left = $urandom_range(60, 10);
      end
      phase_left--;
      quiet <= (n >= 500 && n < 700);
      pop_pct = (mode == 0) ? 20 : (mode == 1) ? 80 : 50;
      is_pop  = ($urandom_range(99) < pop_pct);
      at_back = 1'($urandom_range(1));
      case ($urandom_range(7))
        0:       word = 32'h8000_0000;
        1:       word = 32'h7FFF_FFFF;
        2:       word = '0;
        3:       word = '1;
        default: word = $urandom;
      endcase
      send_request(deq_pkg::action_t'({is_pop, at_back}), word);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
